@@ hw/rtl/lad_pkg.sv @@
// shared constants, codes and structs for the linear array deque
package lad_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int OFS_W  = 5;
    localparam int ST_W   = 2;
    localparam int POS_W  = ((IDX_W > OFS_W) ? IDX_W : OFS_W) + 2;

    localparam int IN_FIELDS_W  = OP_W + VAL_W + OFS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VAL_W + ST_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic signed [IDX_W-1:0] RESET_IDX = '1;
    localparam logic signed [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_UNDER   = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_ONES,
        RD_MEM
    } rd_sel_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        rd_sel_t sel;
        status_t status;
        logic    is_empty;
        logic    is_full;
    } res_info_t;

endpackage

@@ hw/rtl/lad_ram.sv @@
// single-port synchronous ram, registered read data
module lad_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lad_ctrl.sv @@
// front/back index registers and per-operation decision logic
module lad_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [lad_pkg::OP_W-1:0]  op,
    input  logic [lad_pkg::VAL_W-1:0] value,
    input  logic [lad_pkg::OFS_W-1:0] offset,
    output lad_pkg::mem_req_t         mem_req,
    output lad_pkg::res_info_t        res_info
);
    import lad_pkg::*;

    logic signed [IDX_W-1:0] front_reg, front_next;
    logic signed [IDX_W-1:0] back_reg, back_next;
    logic signed [IDX_W-1:0] front_inc, back_inc, front_dec, back_dec;
    logic signed [POS_W-1:0] pos, back_pos;
    logic                    empty_now, full_now, peek_bad;
    mem_req_t                req;
    rd_sel_t                 sel;
    status_t                 status;

    assign empty_now = (front_reg == back_reg);
    assign full_now  = (back_reg == LAST_IDX);
    assign front_inc = front_reg + IDX_W'(1);
    assign back_inc  = back_reg + IDX_W'(1);
    assign front_dec = front_reg - IDX_W'(1);
    assign back_dec  = back_reg - IDX_W'(1);

    // peek position, sign-extended front plus zero-extended offset
    assign pos      = signed'({{(POS_W-IDX_W){front_reg[IDX_W-1]}}, front_reg})
                    + signed'({{(POS_W-OFS_W){1'b0}}, offset});
    assign back_pos = signed'({{(POS_W-IDX_W){back_reg[IDX_W-1]}}, back_reg});
    assign peek_bad = (offset == '0) || (pos > back_pos) || pos[POS_W-1]
                    || (pos >= DEPTH_POS);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        req.en     = 1'b0;
        req.we     = 1'b0;
        req.addr   = '0;
        req.wdata  = value;
        sel        = RD_ZERO;
        status     = ST_OK;
        case (op_t'(op))
            OP_PUSH_BACK:
            begin
                if (full_now)
                begin
                    status = ST_NOSPACE;
                end
                else
                begin
                    back_next = back_inc;
                    req.en    = 1'b1;
                    req.we    = 1'b1;
                    req.addr  = back_inc[ADDR_W-1:0];
                end
            end
            OP_PUSH_FRONT:
            begin
                if (front_reg[IDX_W-1])
                begin
                    status = ST_NOSPACE;
                end
                else
                begin
                    front_next = front_dec;
                    req.en     = 1'b1;
                    req.we     = 1'b1;
                    req.addr   = front_reg[ADDR_W-1:0];
                end
            end
            OP_POP_FRONT:
            begin
                if (empty_now)
                begin
                    sel    = RD_ONES;
                    status = ST_UNDER;
                end
                else
                begin
                    front_next = front_inc;
                    req.en     = 1'b1;
                    req.addr   = front_inc[ADDR_W-1:0];
                    sel        = RD_MEM;
                end
            end
            OP_POP_BACK:
            begin
                if (empty_now)
                begin
                    sel    = RD_ONES;
                    status = ST_UNDER;
                end
                else
                begin
                    back_next = back_dec;
                    req.en    = 1'b1;
                    req.addr  = back_reg[ADDR_W-1:0];
                    sel       = RD_MEM;
                end
            end
            OP_PEEK:
            begin
                if (peek_bad)
                begin
                    sel    = RD_ONES;
                    status = ST_RANGE;
                end
                else
                begin
                    req.en   = 1'b1;
                    req.addr = pos[ADDR_W-1:0];
                    sel      = RD_MEM;
                end
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= RESET_IDX;
            back_reg  <= RESET_IDX;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
        end
    end

    always_comb
    begin
        mem_req           = req;
        mem_req.en        = req.en & accept;
        res_info.sel      = sel;
        res_info.status   = status;
        res_info.is_empty = (front_next == back_next);
        res_info.is_full  = (back_next == LAST_IDX);
    end

endmodule

@@ hw/rtl/linear_array_deque_top.sv @@
// top level of the linear array deque: stream ports, result pipeline
//
// double-ended queue of DEPTH 32-bit words kept in a linear array
// - input channel s_*: one beat is one operation (push back, push front,
//   pop front, pop back, peek) with its value and peek offset
// - output channel m_*: exactly one result beat per input beat, in order,
//   carrying the read word, a status code and the empty/full flags
// - an operation's index update and its single ram access both happen on
//   the accepting edge; the ram's registered read data is folded into the
//   output register once that register is free or draining, so m_tvalid
//   rises when the output register takes the pending result
// - throughput is one beat per cycle while the receiver keeps up: the ram
//   port and the index update each see one operation per cycle, and a
//   write followed by a read of the same slot is ordered by the ram itself
// - a pending stage and an output register decouple the two sides; if the
//   receiver stalls, up to two results are held and s_tready drops only
//   once both are occupied
// - reset (rst_n low) sets both indices to minus one, i.e. an empty queue
//   with no free front slot, and drops both valid flags; ram contents are
//   left as they are, no unwritten slot can ever be read
module linear_array_deque_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // op [2:0], value [34:3], offset [39:35]
    input  logic [lad_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // read_value [31:0], status [33:32], is_empty [34], is_full [35], zero pad
    output logic [lad_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import lad_pkg::*;

    logic [OP_W-1:0]         in_op;
    logic [VAL_W-1:0]        in_value;
    logic [OFS_W-1:0]        in_offset;
    logic                    accept;
    mem_req_t                mem_req;
    res_info_t               res_info;
    logic [VAL_W-1:0]        ram_rdata;

    // pending stage: ram access issued, read data arrives this cycle
    logic                    p_valid_reg;
    res_info_t               p_info_reg;
    logic                    p_move;

    // output register
    logic                    m_valid_reg;
    logic [OUT_FIELDS_W-1:0] m_data_reg;
    logic [OUT_FIELDS_W-1:0] m_data_next;
    logic [VAL_W-1:0]        rd_value;

    // unpack the input beat
    assign in_op     = s_tdata[OP_W-1:0];
    assign in_value  = s_tdata[OP_W +: VAL_W];
    assign in_offset = s_tdata[OP_W+VAL_W +: OFS_W];

    // the pending result moves on when the output register is free or draining
    assign p_move   = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || p_move;
    assign accept   = s_tvalid && s_tready;

    lad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .op       (in_op),
        .value    (in_value),
        .offset   (in_offset),
        .mem_req  (mem_req),
        .res_info (res_info)
    );

    lad_ram #(
        .DATA_W (VAL_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            p_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_info_reg <= res_info;
        end
    end

    // select the read word: ram data, all ones on a failed pop or peek, zero otherwise
    always_comb
    begin
        case (p_info_reg.sel)
            RD_MEM:  rd_value = ram_rdata;
            RD_ONES: rd_value = '1;
            default: rd_value = '0;
        endcase
        m_data_next = {p_info_reg.is_full, p_info_reg.is_empty,
                       p_info_reg.status, rd_value};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (!m_valid_reg || m_tready)
        begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, m_data_reg};

endmodule

@@ hw/rtl/lad_checker.sv @@
// port-level checks for the linear array deque, bound to the top level
module lad_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic [lad_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lad_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import lad_pkg::*;

    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_value;
    logic             r_empty;

    assign r_value  = m_tdata[VAL_W-1:0];
    assign r_status = m_tdata[VAL_W +: ST_W];
    assign r_empty  = m_tdata[VAL_W+ST_W];

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // failed pops and peeks return all ones
    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (r_status == ST_UNDER || r_status == ST_RANGE)
        |-> r_value == '1)
        else $error("failed read did not return minus one");

    // a refused push returns zero
    a_nospace_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r_status == ST_NOSPACE |-> r_value == '0)
        else $error("refused push returned a nonzero word");

    // an underflow leaves the queue empty
    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r_status == ST_UNDER |-> r_empty)
        else $error("underflow reported on a non-empty queue");

endmodule

bind linear_array_deque_top lad_checker u_lad_checker (.*);

@@ tb/sv/linear_array_deque_top_tb.sv @@
// self-checking testbench for the linear array deque top level
module linear_array_deque_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lad_pkg::*;

    // op codes the block leaves undefined; they must pass through as no-ops
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    localparam logic [VAL_W-1:0] WORD_NONE  = '1;
    localparam int               NO_INDEX   = -1;
    localparam int               RANDOM_OPS = 1950;
    localparam int               TAIL_OPS   = 200;
    localparam int               LONG_HOLD  = 80;
    localparam int               NUM_DIR    = 20;

    // one result beat as the block reports it
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        status_t          status;
        logic             is_empty;
        logic             is_full;
    } deque_result_t;

    // one directed row; reps > 1 repeats the row with value bumped per beat
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [OFS_W-1:0] offset;
        logic [4:0]       reps;
        logic             typed;
        deque_result_t    res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;

    // mirror of the deque contents and indices
    logic [VAL_W-1:0] mirror_slots [DEPTH];
    int               mirror_front;
    int               mirror_back;

    deque_result_t pending_results [$];
    int unsigned   fail_count;
    int unsigned   op_count [8];
    int unsigned   status_count [4];
    bit            no_idle;
    bit            hold_long;

    linear_array_deque_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // directed rows: expectations typed in only for the obvious cases,
    // the rest go through the mirror
    dir_row_t dir_table [NUM_DIR] = '{
        // empty queue after reset: both pops underflow
        '{OP_POP_FRONT,  32'h0,          5'd0,  5'd1,  1'b1, '{WORD_NONE, ST_UNDER, 1'b1, 1'b0}},
        '{OP_POP_BACK,   32'h0,          5'd0,  5'd1,  1'b1, '{WORD_NONE, ST_UNDER, 1'b1, 1'b0}},
        // peek with zero offset and with the largest offset field
        '{OP_PEEK,       32'h0,          5'd0,  5'd1,  1'b1, '{WORD_NONE, ST_RANGE, 1'b1, 1'b0}},
        '{OP_PEEK,       32'h0,          5'd31, 5'd1,  1'b1, '{WORD_NONE, ST_RANGE, 1'b1, 1'b0}},
        // push front before any front pop has freed a slot
        '{OP_PUSH_FRONT, 32'h1234_5678,  5'd0,  5'd1,  1'b1, '{32'h0, ST_NOSPACE, 1'b1, 1'b0}},
        // undefined op codes are no-ops
        '{OP_UNDEF_LO,   32'hFFFF_FFFF,  5'd31, 5'd1,  1'b1, '{32'h0, ST_OK, 1'b1, 1'b0}},
        '{OP_UNDEF_HI,   32'hFFFF_FFFF,  5'd31, 5'd1,  1'b1, '{32'h0, ST_OK, 1'b1, 1'b0}},
        // value extremes
        '{OP_PUSH_BACK,  32'h7FFF_FFFF,  5'd0,  5'd1,  1'b1, '{32'h0, ST_OK, 1'b0, 1'b0}},
        '{OP_PUSH_BACK,  32'h8000_0000,  5'd0,  5'd1,  1'b0, '0},
        '{OP_PUSH_BACK,  32'h0,          5'd0,  5'd1,  1'b0, '0},
        '{OP_PUSH_BACK,  32'hFFFF_FFFF,  5'd0,  5'd1,  1'b0, '0},
        '{OP_PEEK,       32'h0,          5'd1,  5'd1,  1'b0, '0},
        // one past the last live entry
        '{OP_PEEK,       32'h0,          5'd5,  5'd1,  1'b1, '{WORD_NONE, ST_RANGE, 1'b0, 1'b0}},
        // front pop frees slot 0, then push front may reuse it
        '{OP_POP_FRONT,  32'h0,          5'd0,  5'd1,  1'b0, '0},
        '{OP_PUSH_FRONT, 32'h5A5A_5A5A,  5'd0,  5'd1,  1'b0, '0},
        '{OP_POP_BACK,   32'h0,          5'd0,  5'd1,  1'b0, '0},
        // fill to the last slot, then push back on a full array
        '{OP_PUSH_BACK,  32'h0000_0100,  5'd0,  5'd13, 1'b0, '0},
        '{OP_PUSH_BACK,  32'hDEAD_BEEF,  5'd0,  5'd1,  1'b1, '{32'h0, ST_NOSPACE, 1'b0, 1'b1}},
        // peek the whole depth, and one slot past the array
        '{OP_PEEK,       32'h0,          5'd16, 5'd1,  1'b0, '0},
        '{OP_PEEK,       32'h0,          5'd17, 5'd1,  1'b1, '{WORD_NONE, ST_RANGE, 1'b0, 1'b1}}
    };

    // applies one operation to the mirror and returns its result beat
    function automatic deque_result_t deque_apply(input logic [OP_W-1:0] op,
                                                  input logic [VAL_W-1:0] value,
                                                  input logic [OFS_W-1:0] offset);
        deque_result_t res;
        int            pos;
        bit            empty_before;
        res          = '{read_value: '0, status: ST_OK, is_empty: 1'b0, is_full: 1'b0};
        empty_before = (mirror_front == mirror_back);
        case (op_t'(op))
            OP_PUSH_BACK:
            begin
                if (mirror_back >= DEPTH - 1)
                    res.status = ST_NOSPACE;
                else
                begin
                    mirror_back++;
                    mirror_slots[mirror_back] = value;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (mirror_front < 0)
                    res.status = ST_NOSPACE;
                else
                begin
                    mirror_slots[mirror_front] = value;
                    mirror_front--;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty_before)
                begin
                    res.read_value = WORD_NONE;
                    res.status     = ST_UNDER;
                end
                else
                begin
                    mirror_front++;
                    res.read_value = mirror_slots[mirror_front];
                end
            end
            OP_POP_BACK:
            begin
                if (empty_before)
                begin
                    res.read_value = WORD_NONE;
                    res.status     = ST_UNDER;
                end
                else
                begin
                    res.read_value = mirror_slots[mirror_back];
                    mirror_back--;
                end
            end
            OP_PEEK:
            begin
                pos = mirror_front + int'(offset);
                if (offset == 0 || pos > mirror_back || pos < 0 || pos >= DEPTH)
                begin
                    res.read_value = WORD_NONE;
                    res.status     = ST_RANGE;
                end
                else
                    res.read_value = mirror_slots[pos];
            end
            default: ;
        endcase
        res.is_empty = (mirror_front == mirror_back);
        res.is_full  = (mirror_back == DEPTH - 1);
        return res;
    endfunction

    // offers one beat, waits for the handshake and records what should come back
    task automatic offer_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                            input logic [OFS_W-1:0] offset, input bit typed,
                            input deque_result_t typed_res);
        deque_result_t predicted;
        s_tdata  <= IN_TDATA_W'({offset, value, op});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = deque_apply(op, value, offset);
        pending_results.push_back(typed ? typed_res : predicted);
        op_count[op]++;
        // random sender gap, never in the tail
        if (!no_idle && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // op mix shifts between filling, draining and front-heavy stretches
    function automatic logic [OP_W-1:0] pick_op(input int phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        case (phase)
            0:       return roll < 50 ? OP_PUSH_BACK  : roll < 60 ? OP_PUSH_FRONT :
                            roll < 72 ? OP_POP_FRONT  : roll < 80 ? OP_POP_BACK   : OP_PEEK;
            1:       return roll < 20 ? OP_PUSH_BACK  : roll < 30 ? OP_PUSH_FRONT :
                            roll < 55 ? OP_POP_FRONT  : roll < 80 ? OP_POP_BACK   : OP_PEEK;
            default: return roll < 25 ? OP_PUSH_BACK  : roll < 50 ? OP_PUSH_FRONT :
                            roll < 68 ? OP_POP_FRONT  : roll < 80 ? OP_POP_BACK   : OP_PEEK;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // stimulus: reset, directed table, then random beats
    initial
    begin
        logic [OP_W-1:0]  op;
        logic [OFS_W-1:0] offset;
        int               live;
        int unsigned      undef_ops;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        no_idle      = 1'b0;
        hold_long    = 1'b0;
        fail_count   = 0;
        mirror_front = NO_INDEX;
        mirror_back  = NO_INDEX;
        foreach (mirror_slots[i])
            mirror_slots[i] = '0;
        foreach (op_count[i])
            op_count[i] = 0;
        foreach (status_count[i])
            status_count[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[r])
            for (int k = 0; k < int'(dir_table[r].reps); k++)
                offer_op(dir_table[r].op, dir_table[r].value + VAL_W'(k),
                         dir_table[r].offset, dir_table[r].typed, dir_table[r].res);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            // long receiver hold-off while the sender keeps offering
            if (n == 600)
                hold_long = 1'b1;
            // sender pauses until every outstanding result has drained
            if (n == 1000)
            begin
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            if (n == RANDOM_OPS - TAIL_OPS)
                no_idle = 1'b1;
            op   = pick_op((n / 150) % 3);
            live = mirror_back - mirror_front;
            if (op == OP_PEEK && live > 0 && $urandom_range(0, 99) < 75)
                offset = OFS_W'($urandom_range(1, live));
            else
                offset = OFS_W'($urandom_range(0, 31));
            offer_op(op, pick_value(), offset, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);

        undef_ops = 0;
        for (int c = int'(OP_UNDEF_LO); c <= int'(OP_UNDEF_HI); c++)
            undef_ops += op_count[c];
        $display("ops: push back %0d, push front %0d, pop front %0d, pop back %0d,",
                 op_count[OP_PUSH_BACK], op_count[OP_PUSH_FRONT], op_count[OP_POP_FRONT],
                 op_count[OP_POP_BACK], " peek %0d, undefined %0d",
                 op_count[OP_PEEK], undef_ops);
        $display("results: ok %0d, no space %0d, underflow %0d,",
                 status_count[ST_OK], status_count[ST_NOSPACE], status_count[ST_UNDER],
                 " peek out of range %0d, mismatches %0d",
                 status_count[ST_RANGE], fail_count);
        if (fail_count == 0)
            $display("[linear_array_deque_top] OK");
        else
            $display("[linear_array_deque_top] ERROR");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request, none in the tail
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rst_n && !no_idle && $urandom_range(0, 99) < 12)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        deque_result_t want;
        deque_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.read_value = m_tdata[31:0];
            got.status     = status_t'(m_tdata[33:32]);
            got.is_empty   = m_tdata[34];
            got.is_full    = m_tdata[35];
            status_count[got.status]++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
                    fail_count++;
                end
                if (got.is_full !== want.is_full)
                begin
                    $error("is_full: expected %b, got %b", want.is_full, got.is_full);
                    fail_count++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[linear_array_deque_top] ERROR");
        $finish;
    end

endmodule
